@@ design/ctsp_pkg.sv @@
// Shared types and constants for the transaction stream parser.
package ctsp_pkg;

    localparam int HASH_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH = 2;

    // byte classes
    localparam logic [3:0] CL_VER     = 4'd0;
    localparam logic [3:0] CL_INCNT   = 4'd1;
    localparam logic [3:0] CL_HASH    = 4'd2;
    localparam logic [3:0] CL_PIDX    = 4'd3;
    localparam logic [3:0] CL_ISLEN   = 4'd4;
    localparam logic [3:0] CL_PUSHOP  = 4'd5;
    localparam logic [3:0] CL_PUSHDAT = 4'd6;
    localparam logic [3:0] CL_SEQ     = 4'd7;
    localparam logic [3:0] CL_OUTCNT  = 4'd8;
    localparam logic [3:0] CL_VALUE   = 4'd9;
    localparam logic [3:0] CL_OSLEN   = 4'd10;
    localparam logic [3:0] CL_OSCR    = 4'd11;
    localparam logic [3:0] CL_LOCK    = 4'd12;

    // status codes
    localparam logic [3:0] ST_RUN      = 4'd0;
    localparam logic [3:0] ST_OK       = 4'd1;
    localparam logic [3:0] ST_BAD_HDR  = 4'd2;
    localparam logic [3:0] ST_BAD_VER  = 4'd3;
    localparam logic [3:0] ST_BAD_OP   = 4'd4;
    localparam logic [3:0] ST_OVERRUN  = 4'd5;
    localparam logic [3:0] ST_TRUNC    = 4'd6;
    localparam logic [3:0] ST_TRAIL    = 4'd7;
    localparam logic [3:0] ST_TOO_BIG  = 4'd8;

    // parse phases
    localparam logic [3:0] PH_VER    = 4'd0;
    localparam logic [3:0] PH_INCNT  = 4'd1;
    localparam logic [3:0] PH_HASH   = 4'd2;
    localparam logic [3:0] PH_PIDX   = 4'd3;
    localparam logic [3:0] PH_ISLEN  = 4'd4;
    localparam logic [3:0] PH_ISCR   = 4'd5;
    localparam logic [3:0] PH_SEQ    = 4'd6;
    localparam logic [3:0] PH_OUTCNT = 4'd7;
    localparam logic [3:0] PH_VAL    = 4'd8;
    localparam logic [3:0] PH_OSLEN  = 4'd9;
    localparam logic [3:0] PH_OSCR   = 4'd10;
    localparam logic [3:0] PH_LOCK   = 4'd11;
    localparam logic [3:0] PH_DONE   = 4'd12;
    localparam logic [3:0] PH_ERR    = 4'd13;

    // push sub-phases
    localparam logic [1:0] PU_OP   = 2'd0;
    localparam logic [1:0] PU_LEN  = 2'd1;
    localparam logic [1:0] PU_DATA = 2'd2;

    localparam logic [7:0] OP_DIRECT_MAX = 8'd75;
    localparam logic [7:0] OP_PD1 = 8'd76;
    localparam logic [7:0] OP_PD2 = 8'd77;
    localparam logic [7:0] OP_PD4 = 8'd78;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [3:0]  byte_class;
        logic [4:0]  field_offset;
        logic [31:0] entry_index;
        logic        push_start;
        logic        field_done;
        logic [63:0] field_value;
        logic [3:0]  status;
        logic        frame_end;
    } out_beat_t;

endpackage

@@ design/ctsp_queue.sv @@
// Small valid/ready FIFO between front and back stages.
module ctsp_queue #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != (AW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;
    assign out_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (AW+1)'(DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> !pop)
        else $error("pop from empty queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push not counted");
endmodule

@@ design/ctsp_parser.sv @@
// Back stage: per-byte parse state machine with registered result.
module ctsp_parser #(
    parameter int HASH_BYTES = ctsp_pkg::HASH_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ctsp_pkg::in_beat_t in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output ctsp_pkg::out_beat_t out_beat
);
    import ctsp_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [3:0]  cw_reg, cw_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] ent_reg, ent_next;
    logic [31:0] sleft_reg, sleft_next;
    logic [1:0]  pu_reg, pu_next;
    logic [31:0] pleft_reg, pleft_next;
    logic [3:0]  err_reg, err_next;
    logic        ovalid_reg;
    out_beat_t   obeat_reg, obeat_next;

    logic        take;
    logic [7:0]  b;
    logic        last;

    assign in_ready  = !ovalid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = ovalid_reg;
    assign out_beat  = obeat_reg;
    assign b    = in_beat.data_byte;
    assign last = in_beat.last_byte;

    always_comb begin
        logic [3:0]  cls, e;
        logic [4:0]  offw;
        logic [31:0] entv;
        logic        ps, fd, was_hdr;
        logic [3:0]  st;
        logic [2:0]  o3;
        logic [3:0]  o4;
        logic [2:0]  w;
        logic [31:0] sl;
        cls = CL_VER; offw = '0; entv = '0; ps = 1'b0; fd = 1'b0; e = ST_RUN;
        o3 = '0; o4 = '0; w = '0; sl = '0; st = ST_RUN;
        was_hdr = (phase_reg == PH_VER);
        phase_next = phase_reg; cnt_next = cnt_reg; cw_next = cw_reg;
        acc_next = acc_reg; left_next = left_reg; ent_next = ent_reg;
        sleft_next = sleft_reg; pu_next = pu_reg; pleft_next = pleft_reg;
        err_next = err_reg;

        unique case (phase_reg)
            PH_VER, PH_PIDX, PH_SEQ, PH_VAL, PH_LOCK: begin
                o3 = cnt_reg[2:0];
                offw = {2'b0, o3};
                if (phase_reg == PH_VER) cls = CL_VER;
                else if (phase_reg == PH_PIDX) cls = CL_PIDX;
                else if (phase_reg == PH_SEQ) cls = CL_SEQ;
                else if (phase_reg == PH_VAL) cls = CL_VALUE;
                else cls = CL_LOCK;
                if (phase_reg != PH_VER && phase_reg != PH_LOCK) entv = ent_reg;
                acc_next = (o3 == 3'd0) ? 64'd0 : acc_reg;
                acc_next[{o3, 3'b000} +: 8] = b;
                cnt_next = 6'(o3) + 6'd1;
                if (cnt_next >= ((phase_reg == PH_VAL) ? 6'd8 : 6'd4)) begin
                    fd = 1'b1;
                    cnt_next = '0;
                end
                if (phase_reg == PH_VER) begin
                    if (o3 != 3'd0 && b != 8'd0) e = ST_BAD_HDR;
                    else if (fd && acc_next[7:0] > 8'd2) e = ST_BAD_VER;
                    if (fd) phase_next = PH_INCNT;
                end else if (fd) begin
                    if (phase_reg == PH_PIDX) phase_next = PH_ISLEN;
                    else if (phase_reg == PH_VAL) phase_next = PH_OSLEN;
                    else if (phase_reg == PH_LOCK) phase_next = PH_DONE;
                    else begin
                        left_next = left_reg - 32'd1;
                        ent_next  = ent_reg + 32'd1;
                        phase_next = (left_next != '0) ? PH_HASH : PH_OUTCNT;
                    end
                end
            end
            PH_INCNT, PH_OUTCNT, PH_ISLEN, PH_OSLEN: begin
                if (phase_reg == PH_INCNT) cls = CL_INCNT;
                else if (phase_reg == PH_OUTCNT) cls = CL_OUTCNT;
                else if (phase_reg == PH_ISLEN) cls = CL_ISLEN;
                else cls = CL_OSLEN;
                if (phase_reg == PH_ISLEN || phase_reg == PH_OSLEN) entv = ent_reg;
                o4 = cnt_reg[3:0];
                offw = {1'b0, o4};
                if (o4 == 4'd0) begin
                    if (b < 8'hFD) begin
                        acc_next = {56'd0, b};
                        fd = 1'b1;
                    end else begin
                        cw_next = (b == 8'hFD) ? 4'd2 : (b == 8'hFE) ? 4'd4 : 4'd8;
                        acc_next = '0;
                        cnt_next = 6'd1;
                    end
                end else begin
                    o3 = 3'(o4 - 4'd1);
                    acc_next[{o3, 3'b000} +: 8] = b;
                    if (o4 >= cw_reg) begin
                        fd = 1'b1;
                        cnt_next = '0;
                    end else begin
                        cnt_next = 6'(o4) + 6'd1;
                    end
                end
                if (fd) begin
                    if (acc_next[63:32] != '0) begin
                        e = ST_TOO_BIG;
                    end else if (phase_reg == PH_INCNT || phase_reg == PH_OUTCNT) begin
                        left_next = acc_next[31:0];
                        ent_next = '0;
                        if (phase_reg == PH_INCNT)
                            phase_next = (acc_next[31:0] != '0) ? PH_HASH : PH_OUTCNT;
                        else
                            phase_next = (acc_next[31:0] != '0) ? PH_VAL : PH_LOCK;
                    end else begin
                        sleft_next = acc_next[31:0];
                        pu_next = PU_OP;
                        if (phase_reg == PH_ISLEN)
                            phase_next = (acc_next[31:0] != '0) ? PH_ISCR : PH_SEQ;
                        else if (acc_next[31:0] != '0)
                            phase_next = PH_OSCR;
                        else begin
                            left_next = left_reg - 32'd1;
                            ent_next = ent_reg + 32'd1;
                            phase_next = (left_next != '0) ? PH_VAL : PH_LOCK;
                        end
                    end
                end
            end
            PH_HASH: begin
                cls = CL_HASH;
                entv = ent_reg;
                offw = cnt_reg[4:0];
                cnt_next = cnt_reg + 6'd1;
                if (cnt_next >= 6'(HASH_BYTES)) begin
                    cnt_next = '0;
                    phase_next = PH_PIDX;
                end
            end
            PH_ISCR: begin
                entv = ent_reg;
                sl = sleft_reg - 32'd1;
                sleft_next = sl;
                case (pu_reg)
                    PU_OP: begin
                        cls = CL_PUSHOP;
                        ps = 1'b1;
                        if (b == 8'd0) begin
                        end else if (b <= OP_DIRECT_MAX) begin
                            if (32'(b) > sl) e = ST_OVERRUN;
                            else begin
                                pleft_next = 32'(b);
                                pu_next = PU_DATA;
                            end
                        end else if (b <= OP_PD4) begin
                            w = (b == OP_PD1) ? 3'd1 : (b == OP_PD2) ? 3'd2 : 3'd4;
                            if (32'(w) > sl) e = ST_OVERRUN;
                            else begin
                                cw_next = 4'(w);
                                cnt_next = '0;
                                acc_next = '0;
                                pu_next = PU_LEN;
                            end
                        end else begin
                            e = ST_BAD_OP;
                        end
                    end
                    PU_LEN: begin
                        cls = CL_PUSHOP;
                        acc_next[{1'b0, cnt_reg[1:0], 3'b000} +: 8] = b;
                        cnt_next = cnt_reg + 6'd1;
                        if (cnt_next >= 6'(cw_reg)) begin
                            fd = 1'b1;
                            cnt_next = '0;
                            if (acc_next > 64'(sl)) e = ST_OVERRUN;
                            else if (acc_next == '0) pu_next = PU_OP;
                            else begin
                                pleft_next = acc_next[31:0];
                                pu_next = PU_DATA;
                            end
                        end
                    end
                    default: begin
                        cls = CL_PUSHDAT;
                        pleft_next = pleft_reg - 32'd1;
                        if (pleft_next == '0) pu_next = PU_OP;
                    end
                endcase
                if (e == ST_RUN && sl == '0) begin
                    pu_next = PU_OP;
                    cnt_next = '0;
                    phase_next = PH_SEQ;
                end
            end
            PH_OSCR: begin
                cls = CL_OSCR;
                entv = ent_reg;
                sleft_next = sleft_reg - 32'd1;
                if (sleft_next == '0) begin
                    left_next = left_reg - 32'd1;
                    ent_next = ent_reg + 32'd1;
                    phase_next = (left_next != '0) ? PH_VAL : PH_LOCK;
                end
            end
            PH_DONE: e = ST_TRAIL;
            default: ;
        endcase

        if (e != ST_RUN && err_reg == ST_RUN) err_next = e;
        if (err_next != ST_RUN) phase_next = PH_ERR;

        if (err_next != ST_RUN) st = err_next;
        else if (!last) st = ST_RUN;
        else if (phase_next == PH_DONE) st = ST_OK;
        else if (was_hdr) st = ST_BAD_HDR;
        else st = ST_TRUNC;

        obeat_next.byte_class   = cls;
        obeat_next.field_offset = offw;
        obeat_next.entry_index  = entv;
        obeat_next.push_start   = ps;
        obeat_next.field_done   = fd;
        obeat_next.field_value  = fd ? acc_next : 64'd0;
        obeat_next.status       = st;
        obeat_next.frame_end    = last;

        if (last) begin
            phase_next = PH_VER; cnt_next = '0; cw_next = '0; acc_next = '0;
            left_next = '0; ent_next = '0; sleft_next = '0; pu_next = PU_OP;
            pleft_next = '0; err_next = ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_VER; cnt_reg <= '0; cw_reg <= '0; acc_reg <= '0;
            left_reg <= '0; ent_reg <= '0; sleft_reg <= '0; pu_reg <= PU_OP;
            pleft_reg <= '0; err_reg <= ST_RUN; ovalid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg <= phase_next; cnt_reg <= cnt_next; cw_reg <= cw_next;
                acc_reg <= acc_next; left_reg <= left_next; ent_reg <= ent_next;
                sleft_reg <= sleft_next; pu_reg <= pu_next; pleft_reg <= pleft_next;
                err_reg <= err_next;
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            obeat_reg <= obeat_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ST_RUN) |-> phase_reg == PH_ERR)
        else $error("latched error outside error phase");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (take && last) |=> phase_reg == PH_VER && err_reg == ST_RUN)
        else $error("frame end did not restart parser");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");
endmodule

@@ design/coin_transaction_stream_parser.sv @@
// Top level: serialized transaction byte parser.
//
// Input channel s_*: one transaction byte per beat, s_last_byte on the final
// byte of each frame. Result channel m_*: one tagged result beat per input
// beat, in order: class, field offset, entry index, push start flag, numeric
// field completion with its little-endian value, running/final status and
// frame_end echoing the input mark.
// A two-entry queue decouples input acceptance from the parse engine, whose
// result register feeds the m_ channel. Each byte passes through the queue
// storage and then the result register; throughput is one byte per cycle
// while the receiver is ready, set by the parse state update.
// Reset (aresetn low, synchronous) empties the queue and puts the parser in
// its expecting-version state. If the receiver stalls, the result register
// holds, then the queue fills and s_ready drops; nothing is lost.
// After each frame end the parser returns to the expecting-version state.
module coin_transaction_stream_parser #(
    parameter int HASH_BYTES = ctsp_pkg::HASH_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_byte_class,
    output logic [4:0]  m_field_offset,
    output logic [31:0] m_entry_index,
    output logic        m_push_start,
    output logic        m_field_done,
    output logic [63:0] m_field_value,
    output logic [3:0]  m_status,
    output logic        m_frame_end
);
    import ctsp_pkg::*;

    in_beat_t  s_beat, q_beat;
    out_beat_t m_beat;
    logic      q_valid, q_ready;

    assign s_beat.data_byte = s_data_byte;
    assign s_beat.last_byte = s_last_byte;

    ctsp_queue #(.WIDTH($bits(in_beat_t)), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready), .in_data(s_beat),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_beat)
    );

    ctsp_parser #(.HASH_BYTES(HASH_BYTES)) u_parser (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_beat(q_beat),
        .out_valid(m_valid), .out_ready(m_ready), .out_beat(m_beat)
    );

    assign m_byte_class   = m_beat.byte_class;
    assign m_field_offset = m_beat.field_offset;
    assign m_entry_index  = m_beat.entry_index;
    assign m_push_start   = m_beat.push_start;
    assign m_field_done   = m_beat.field_done;
    assign m_field_value  = m_beat.field_value;
    assign m_status       = m_beat.status;
    assign m_frame_end    = m_beat.frame_end;
endmodule

@@ verif/coin_transaction_stream_parser_tb.sv @@
// Testbench for the transaction stream parser: predicted result beats checked against the m_ channel.
module coin_transaction_stream_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ctsp_pkg::*;

    typedef struct packed {
        logic [3:0]  byte_class;
        logic [4:0]  field_offset;
        logic [31:0] entry_index;
        logic        push_start;
        logic        field_done;
        logic [63:0] field_value;
        logic [3:0]  status;
        logic        frame_end;
    } tag_t;

    // Predictor of the parser plus the queue of tags it expects.
    class tag_scoreboard;
        logic [3:0]  phase;
        int unsigned cnt;
        int unsigned cwidth;
        logic [63:0] acc;
        logic [31:0] left;
        logic [31:0] entry;
        logic [31:0] script_left;
        logic [1:0]  push_ph;
        logic [31:0] push_left;
        logic [3:0]  err_code;
        tag_t        pending[$];
        int          mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_VER;
            cnt = 0;
            cwidth = 0;
            acc = 0;
            left = 0;
            entry = 0;
            script_left = 0;
            push_ph = PU_OP;
            push_left = 0;
            err_code = ST_RUN;
        endfunction

        function int unsigned fixed_byte(logic [7:0] b, int unsigned n, output bit done);
            int unsigned o;
            o = cnt & 7;
            if (o == 0) acc = 0;
            acc |= 64'(b) << (8 * o);
            cnt = o + 1;
            done = 0;
            if (cnt >= n) begin
                done = 1;
                cnt = 0;
            end
            return o;
        endfunction

        function int unsigned compact_byte(logic [7:0] b, output bit done);
            int unsigned o;
            o = cnt & 15;
            done = 0;
            if (o == 0) begin
                if (b < 8'hFD) begin
                    acc = 64'(b);
                    done = 1;
                end else begin
                    cwidth = (b == 8'hFD) ? 2 : (b == 8'hFE) ? 4 : 8;
                    acc = 0;
                    cnt = 1;
                end
            end else begin
                acc |= 64'(b) << (8 * ((o - 1) & 7));
                if (o >= cwidth) begin
                    done = 1;
                    cnt = 0;
                end else begin
                    cnt = o + 1;
                end
            end
            return o;
        endfunction

        function void step_output();
            left--;
            entry++;
            phase = (left != 0) ? PH_VAL : PH_LOCK;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            tag_t t;
            logic [3:0] e;
            bit fd;
            bit hdr;
            int unsigned w;
            t = '0;
            e = ST_RUN;
            fd = 0;
            hdr = (phase == PH_VER);
            case (phase)
                PH_VER: begin
                    t.field_offset = 5'(fixed_byte(b, 4, fd));
                    if (t.field_offset != 0 && b != 0) e = ST_BAD_HDR;
                    else if (fd && acc[7:0] > 2) e = ST_BAD_VER;
                    if (fd) phase = PH_INCNT;
                end
                PH_INCNT, PH_OUTCNT: begin
                    t.byte_class = (phase == PH_INCNT) ? CL_INCNT : CL_OUTCNT;
                    t.field_offset = 5'(compact_byte(b, fd));
                    if (fd) begin
                        if (acc > 64'hFFFF_FFFF) e = ST_TOO_BIG;
                        else begin
                            left = acc[31:0];
                            entry = 0;
                            if (t.byte_class == CL_INCNT)
                                phase = (acc != 0) ? PH_HASH : PH_OUTCNT;
                            else
                                phase = (acc != 0) ? PH_VAL : PH_LOCK;
                        end
                    end
                end
                PH_HASH: begin
                    t.byte_class = CL_HASH;
                    t.entry_index = entry;
                    t.field_offset = 5'(cnt & 31);
                    cnt = (cnt & 63) + 1;
                    if (cnt >= HASH_BYTES_DEF) begin
                        cnt = 0;
                        phase = PH_PIDX;
                    end
                end
                PH_PIDX: begin
                    t.byte_class = CL_PIDX;
                    t.entry_index = entry;
                    t.field_offset = 5'(fixed_byte(b, 4, fd));
                    if (fd) phase = PH_ISLEN;
                end
                PH_ISLEN, PH_OSLEN: begin
                    t.byte_class = (phase == PH_ISLEN) ? CL_ISLEN : CL_OSLEN;
                    t.entry_index = entry;
                    t.field_offset = 5'(compact_byte(b, fd));
                    if (fd) begin
                        if (acc > 64'hFFFF_FFFF) e = ST_TOO_BIG;
                        else begin
                            script_left = acc[31:0];
                            push_ph = PU_OP;
                            if (t.byte_class == CL_ISLEN)
                                phase = (acc != 0) ? PH_ISCR : PH_SEQ;
                            else if (acc != 0) phase = PH_OSCR;
                            else step_output();
                        end
                    end
                end
                PH_ISCR: begin
                    t.entry_index = entry;
                    script_left--;
                    if (push_ph == PU_OP) begin
                        t.byte_class = CL_PUSHOP;
                        t.push_start = 1;
                        if (b == 0) begin
                        end else if (b <= OP_DIRECT_MAX) begin
                            if (32'(b) > script_left) e = ST_OVERRUN;
                            else begin
                                push_left = 32'(b);
                                push_ph = PU_DATA;
                            end
                        end else if (b <= OP_PD4) begin
                            w = (b == OP_PD1) ? 1 : (b == OP_PD2) ? 2 : 4;
                            if (w > script_left) e = ST_OVERRUN;
                            else begin
                                cwidth = w;
                                cnt = 0;
                                acc = 0;
                                push_ph = PU_LEN;
                            end
                        end else begin
                            e = ST_BAD_OP;
                        end
                    end else if (push_ph == PU_LEN) begin
                        t.byte_class = CL_PUSHOP;
                        acc |= 64'(b) << (8 * (cnt & 3));
                        cnt++;
                        if (cnt >= cwidth) begin
                            fd = 1;
                            cnt = 0;
                            if (acc > 64'(script_left)) e = ST_OVERRUN;
                            else if (acc == 0) push_ph = PU_OP;
                            else begin
                                push_left = acc[31:0];
                                push_ph = PU_DATA;
                            end
                        end
                    end else begin
                        t.byte_class = CL_PUSHDAT;
                        push_left--;
                        if (push_left == 0) push_ph = PU_OP;
                    end
                    if (e == ST_RUN && script_left == 0) begin
                        push_ph = PU_OP;
                        cnt = 0;
                        phase = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    t.byte_class = CL_SEQ;
                    t.entry_index = entry;
                    t.field_offset = 5'(fixed_byte(b, 4, fd));
                    if (fd) begin
                        left--;
                        entry++;
                        phase = (left != 0) ? PH_HASH : PH_OUTCNT;
                    end
                end
                PH_VAL: begin
                    t.byte_class = CL_VALUE;
                    t.entry_index = entry;
                    t.field_offset = 5'(fixed_byte(b, 8, fd));
                    if (fd) phase = PH_OSLEN;
                end
                PH_OSCR: begin
                    t.byte_class = CL_OSCR;
                    t.entry_index = entry;
                    script_left--;
                    if (script_left == 0) step_output();
                end
                PH_LOCK: begin
                    t.byte_class = CL_LOCK;
                    t.field_offset = 5'(fixed_byte(b, 4, fd));
                    if (fd) phase = PH_DONE;
                end
                PH_DONE: e = ST_TRAIL;
                default: ;
            endcase
            if (e != ST_RUN && err_code == ST_RUN) err_code = e;
            if (err_code != ST_RUN) phase = PH_ERR;
            if (err_code != ST_RUN) t.status = err_code;
            else if (!last) t.status = ST_RUN;
            else if (phase == PH_DONE) t.status = ST_OK;
            else if (hdr) t.status = ST_BAD_HDR;
            else t.status = ST_TRUNC;
            t.field_done = fd;
            t.field_value = fd ? acc : 64'd0;
            t.frame_end = last;
            pending.push_back(t);
            if (last) clear();
        endfunction

        function void check_tag(tag_t got);
            tag_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tag mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    tag_t        got;

    tag_scoreboard sb;
    byte unsigned frame[$];
    bit          long_stall;
    longint      cycles;
    int          sent_beats;

    coin_transaction_stream_parser i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_data_byte(s_data_byte), .s_last_byte(s_last_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_byte_class(got.byte_class), .m_field_offset(got.field_offset),
        .m_entry_index(got.entry_index), .m_push_start(got.push_start),
        .m_field_done(got.field_done), .m_field_value(got.field_value),
        .m_status(got.status), .m_frame_end(got.frame_end)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 400000) begin
                $display("coin_transaction_stream_parser_tb NOT OK");
                $finish;
            end
        end
    end

    // Sends one beat; s_valid stays high straight into the next beat when no gap is drawn.
    task automatic send_beat(logic [7:0] b, logic last);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, last);
        sent_beats++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame.size(); i++)
            send_beat(frame[i], i == frame.size() - 1);
        frame.delete();
    endtask

    task automatic put_le(longint unsigned v, int n);
        for (int i = 0; i < n; i++) frame.push_back(8'(v >> (8 * i)));
    endtask

    task automatic put_compact(longint unsigned v);
        int k;
        k = $urandom_range(0, 7);
        if (v < 253 && k != 0) frame.push_back(8'(v));
        else if (v < 65536 && k < 4) begin
            frame.push_back(8'hFD);
            put_le(v, 2);
        end else if (v <= 64'hFFFF_FFFF && k < 6) begin
            frame.push_back(8'hFE);
            put_le(v, 4);
        end else begin
            frame.push_back(8'hFF);
            put_le(v, 8);
        end
    endtask

    // Input script of exactly len bytes built from random pushes.
    task automatic put_script(int len);
        int rem, n, w;
        rem = len;
        while (rem > 0) begin
            if (rem == 1 || $urandom_range(0, 5) == 0) begin
                frame.push_back(8'd0);
                rem--;
            end else if ($urandom_range(0, 2) != 0 || rem < 3) begin
                n = $urandom_range(1, (rem - 1 > 75) ? 75 : rem - 1);
                frame.push_back(8'(n));
                repeat (n) frame.push_back(8'($urandom));
                rem -= n + 1;
            end else begin
                w = $urandom_range(0, 2);
                w = (w == 0) ? 1 : (w == 1) ? 2 : 4;
                if (rem < w + 1) w = 1;
                n = $urandom_range(0, rem - 1 - w);
                frame.push_back((w == 1) ? OP_PD1 : (w == 2) ? OP_PD2 : OP_PD4);
                put_le(n, w);
                repeat (n) frame.push_back(8'($urandom));
                rem -= n + 1 + w;
            end
        end
    endtask

    task automatic build_tx(int nin, int nout);
        int sl;
        put_le($urandom_range(0, 2), 4);
        put_compact(nin);
        for (int i = 0; i < nin; i++) begin
            repeat (32) frame.push_back(8'($urandom));
            put_le($urandom, 4);
            sl = $urandom_range(0, 12);
            put_compact(sl);
            put_script(sl);
            put_le($urandom, 4);
        end
        put_compact(nout);
        for (int i = 0; i < nout; i++) begin
            put_le({$urandom, $urandom}, 8);
            sl = $urandom_range(0, 6);
            put_compact(sl);
            repeat (sl) frame.push_back(8'($urandom));
        end
        put_le($urandom, 4);
    endtask

    task automatic random_frame();
        int k, cut;
        build_tx($urandom_range(0, 2), $urandom_range(0, 2));
        k = $urandom_range(0, 9);
        if (k == 0) begin
            cut = $urandom_range(1, frame.size());
            while (frame.size() > cut) void'(frame.pop_back());
        end else if (k == 1) begin
            frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
        end else if (k == 2) begin
            repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
        end
        send_frame();
    endtask

    // Receiver: random stalls, plus one long hold-off once long_stall is raised.
    initial begin
        int gap;
        m_ready = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_stall) begin
                m_ready <= 0;
                repeat (200) @(posedge aclk);
                long_stall = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_tag(got);
        end
    end

    initial begin
        sb = new();
        aresetn = 0;
        s_valid = 0;
        s_data_byte = 0;
        s_last_byte = 0;
        long_stall = 0;
        sent_beats = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: good frame, bad header, bad version, bad opcode, overrun,
        // oversized count, trailing byte, short frame
        build_tx(1, 1);
        send_frame();
        put_le(32'h0001_0001, 4); send_frame();
        put_le(3, 4); frame.push_back(0); send_frame();
        put_le(1, 4); frame.push_back(1); repeat (36) frame.push_back(8'hFF);
        frame.push_back(2); frame.push_back(8'hFF); frame.push_back(0); send_frame();
        put_le(2, 4); frame.push_back(1); repeat (36) frame.push_back(0);
        frame.push_back(3); frame.push_back(75); frame.push_back(0); send_frame();
        put_le(0, 4); frame.push_back(8'hFF); put_le(64'h1_0000_0000, 8); send_frame();
        put_le(1, 4); frame.push_back(0); frame.push_back(0); put_le(0, 4);
        frame.push_back(8'hAA); send_frame();
        frame.push_back(1); send_frame();
        put_le(2, 4); frame.push_back(1); repeat (36) frame.push_back(8'h5A);
        frame.push_back(6); frame.push_back(OP_PD4); put_le(0, 4);
        frame.push_back(0); put_le(0, 4); send_frame();

        long_stall = 1;
        while (sent_beats < 1250) random_frame();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("coin_transaction_stream_parser_tb OK");
        else
            $display("coin_transaction_stream_parser_tb NOT OK");
        $finish;
    end
endmodule
